@@ sv/prqs_pkg.sv @@
// shared types and codes for the ready queue scheduler
package prqs_pkg;
   typedef enum logic [2:0] {
      OP_READY_TAIL = 3'd0,
      OP_READY_HEAD = 3'd1,
      OP_SWITCH     = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_LOCK       = 3'd4,
      OP_UNLOCK     = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SWITCH_REQ  = 3'd1,
      ST_PENDING     = 3'd2,
      ST_NOT_NEEDED  = 3'd3,
      ST_EMPTY       = 3'd4,
      ST_NOT_QUEUED  = 3'd5
   } status_type;

   localparam int unsigned ID_W   = 5;
   localparam int unsigned PRIO_W = 5;
   localparam logic [7:0] LOCK_MAX = 8'd255;
endpackage

@@ sv/priority_ready_queue_scheduler_core.sv @@
// top level of the priority ready queue scheduler
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_opcode req_task_id req_task_priority
//          |           |           | req_task_preemptible req_running_still_ready
//  result  | rsp_valid | rsp_stall | rsp_status rsp_running_task rsp_running_prio
//          |           |           | rsp_running_valid rsp_highest_ready_prio
//          |           |           | rsp_ready_empty
// one operation per cycle unless the result register is full and stalled: a transfer is latched
// in the input register, then the queue update and find-first-set write the result register
// the update stage stalls only when the result register is full and stalled
// synchronous active high reset clears the ready mask, queued bits, running task,
// lock count and pending flag; link and head/tail tables need no clearing
module priority_ready_queue_scheduler_core #(
   parameter int unsigned NUM_TASKS  = 32,
   parameter int unsigned NUM_LEVELS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_opcode,
   input  logic [prqs_pkg::ID_W-1:0]   req_task_id,
   input  logic [prqs_pkg::PRIO_W-1:0] req_task_priority,
   input  logic                       req_task_preemptible,
   input  logic                       req_running_still_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [prqs_pkg::ID_W-1:0]   rsp_running_task,
   output logic [prqs_pkg::PRIO_W-1:0] rsp_running_prio,
   output logic                       rsp_running_valid,
   output logic [prqs_pkg::PRIO_W-1:0] rsp_highest_ready_prio,
   output logic                       rsp_ready_empty
);
   import prqs_pkg::*;

   localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   // input register
   logic                  in_valid_ff;
   logic [2:0]            in_op_ff;
   logic [ID_W-1:0]       in_id_ff;
   logic [PRIO_W-1:0]     in_prio_ff;
   logic                  in_pre_ff;
   logic                  in_still_ff;

   // scheduler state
   logic [NUM_LEVELS-1:0] ready_mask_ff, ready_mask_in;
   logic [TW-1:0]         level_head_ff [NUM_LEVELS];
   logic [TW-1:0]         level_tail_ff [NUM_LEVELS];
   logic [TW-1:0]         link_next_ff  [NUM_TASKS];
   logic [TW-1:0]         link_prev_ff  [NUM_TASKS];
   logic [LW-1:0]         task_level_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0]  task_pre_ff;
   logic [NUM_TASKS-1:0]  task_queued_ff, task_queued_in;
   logic [TW-1:0]         cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [7:0]            lock_ff, lock_in;
   logic                  pending_ff, pending_in;

   // table writes, up to two link writes per operation
   logic                  hd_we, tl_we, hd2_we;
   logic [LW-1:0]         hd_a, tl_a, hd2_a;
   logic [TW-1:0]         hd_d, tl_d, hd2_d;
   logic                  nx_we, pv_we, nx2_we, pv2_we, lv_we, pre_we;
   logic [TW-1:0]         nx_a, pv_a, nx2_a, pv2_a, lv_a, pre_a;
   logic [TW-1:0]         nx_d, pv_d, nx2_d, pv2_d;
   logic [LW-1:0]         lv_d;
   logic                  pre_d;

   // result register
   logic                  out_valid_ff;
   logic [2:0]            st_ff, st_in;
   logic [ID_W-1:0]       rtask_ff;
   logic [PRIO_W-1:0]     rprio_ff;
   logic                  rvalid_ff;
   logic [PRIO_W-1:0]     hprio_ff;
   logic                  rempty_ff;

   logic work_go;
   assign work_go   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !work_go;

   function automatic logic [LW-1:0] ffs(input logic [NUM_LEVELS-1:0] m);
      logic [LW-1:0] r;
      r = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--)
         if (m[i]) r = LW'(i);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_op_ff    <= req_opcode;
         in_id_ff    <= req_task_id;
         in_prio_ff  <= req_task_priority;
         in_pre_ff   <= req_task_preemptible;
         in_still_ff <= req_running_still_ready;
      end
   end

   // combinational single-pass update
   always_comb begin
      logic [LW-1:0]         lvl, clvl, sel, ulvl;
      logic                  id_ok, atb, do_enq, do_unl;
      logic [TW-1:0]         eid, uid, uh, ut, unx, upv, id_t;
      logic [NUM_LEVELS-1:0] m1;
      logic [NUM_TASKS-1:0]  q1;
      logic                  eq_hit;

      ready_mask_in  = ready_mask_ff;
      task_queued_in = task_queued_ff;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      lock_in        = lock_ff;
      pending_in     = pending_ff;
      st_in          = ST_OK;
      {hd_we, tl_we, hd2_we, nx_we, pv_we, nx2_we, pv2_we, lv_we, pre_we} = '0;
      hd_a = '0; tl_a = '0; hd2_a = '0; hd_d = '0; tl_d = '0; hd2_d = '0;
      nx_a = '0; pv_a = '0; nx2_a = '0; pv2_a = '0; lv_a = '0; pre_a = '0;
      nx_d = '0; pv_d = '0; nx2_d = '0; pv2_d = '0; lv_d = '0; pre_d = 1'b0;
      sel = '0; ulvl = '0; uh = '0; ut = '0; unx = '0; upv = '0;

      lvl   = (32'(in_prio_ff) < NUM_LEVELS) ? LW'(in_prio_ff) : LW'(NUM_LEVELS - 1);
      id_ok = 32'(in_id_ff) < NUM_TASKS;
      id_t  = TW'(in_id_ff);
      clvl  = task_level_ff[cur_ff];
      do_enq = 1'b0; atb = 1'b0; eid = id_t;
      do_unl = 1'b0; uid = id_t;

      unique case (in_op_ff)
         OP_READY_TAIL, OP_READY_HEAD: begin
            if (id_ok && !task_queued_ff[id_t]) begin
               do_enq = 1'b1;
               atb    = (in_op_ff == OP_READY_HEAD);
               pre_we = 1'b1; pre_a = id_t; pre_d = in_pre_ff;
               // readying the running task itself moves it to the new level
               if (cur_valid_ff && id_t != cur_ff && clvl > lvl && task_pre_ff[cur_ff]) begin
                  if (lock_ff == 8'd0) begin
                     st_in = ST_SWITCH_REQ;
                  end else begin
                     pending_in = 1'b1;
                     st_in = ST_PENDING;
                  end
               end else begin
                  st_in = ST_NOT_NEEDED;
               end
            end
         end
         OP_SWITCH: begin
            if (in_still_ff && cur_valid_ff && !task_queued_ff[cur_ff]) begin
               do_enq = 1'b1; atb = 1'b1; eid = cur_ff; lvl = clvl;
            end
         end
         OP_REMOVE: begin
            if (id_ok && task_queued_ff[id_t]) do_unl = 1'b1;
            else st_in = ST_NOT_QUEUED;
         end
         OP_LOCK: begin
            if (cur_valid_ff && task_pre_ff[cur_ff] && lock_ff != LOCK_MAX)
               lock_in = lock_ff + 8'd1;
         end
         OP_UNLOCK: begin
            if (lock_ff != 8'd0) begin
               lock_in = lock_ff - 8'd1;
               if (lock_ff == 8'd1 && pending_ff) begin
                  pending_in = 1'b0;
                  st_in = ST_SWITCH_REQ;
               end
            end
         end
         default: ;
      endcase

      // enqueue part
      m1 = ready_mask_ff;
      q1 = task_queued_ff;
      eq_hit = 1'b0;
      if (do_enq) begin
         lv_we = 1'b1; lv_a = eid; lv_d = lvl;
         q1[eid] = 1'b1;
         if (ready_mask_ff[lvl]) begin
            if (atb) begin
               pv_we = 1'b1; pv_a = level_head_ff[lvl]; pv_d = eid;
               nx_we = 1'b1; nx_a = eid; nx_d = level_head_ff[lvl];
               hd_we = 1'b1; hd_a = lvl; hd_d = eid;
            end else begin
               nx_we = 1'b1; nx_a = level_tail_ff[lvl]; nx_d = eid;
               pv_we = 1'b1; pv_a = eid; pv_d = level_tail_ff[lvl];
               tl_we = 1'b1; tl_a = lvl; tl_d = eid;
            end
         end else begin
            hd_we = 1'b1; hd_a = lvl; hd_d = eid;
            tl_we = 1'b1; tl_a = lvl; tl_d = eid;
            m1[lvl] = 1'b1;
            eq_hit = 1'b1;
         end
      end

      // switch dispatch, seeing the re-queued running task
      if (in_op_ff == OP_SWITCH) begin
         if (m1 == '0) begin
            st_in = ST_EMPTY;
         end else begin
            sel = ffs(m1);
            do_unl = 1'b1;
            // a freshly queued task at its own level is the head of that level
            if (do_enq && sel == lvl) uid = eid;
            else uid = level_head_ff[sel];
            cur_in = uid;
            cur_valid_in = 1'b1;
         end
      end

      // unlink part; a re-queued task only ever lands at a head
      ready_mask_in  = m1;
      task_queued_in = q1;
      if (do_unl) begin
         if (do_enq && uid == eid) begin
            ulvl = lvl;
            uh = eid;
            ut = eq_hit ? eid : level_tail_ff[lvl];
            unx = level_head_ff[lvl];
         end else begin
            ulvl = task_level_ff[uid];
            uh = (do_enq && ulvl == lvl) ? eid : level_head_ff[ulvl];
            ut = level_tail_ff[ulvl];
            unx = link_next_ff[uid];
         end
         upv = link_prev_ff[uid];
         if (do_enq && uid == level_head_ff[lvl] && ulvl == lvl && ready_mask_ff[lvl])
            upv = eid;
         if (uh == uid && ut == uid) begin
            ready_mask_in[ulvl] = 1'b0;
         end else if (uh == uid) begin
            hd2_we = 1'b1; hd2_a = ulvl; hd2_d = unx;
         end else if (ut == uid) begin
            tl_we = 1'b1; tl_a = ulvl; tl_d = upv;
         end else begin
            nx2_we = 1'b1; nx2_a = upv; nx2_d = unx;
            pv2_we = 1'b1; pv2_a = unx; pv2_d = upv;
         end
         task_queued_in[uid] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_mask_ff  <= '0;
         task_queued_ff <= '0;
         cur_ff         <= '0;
         cur_valid_ff   <= 1'b0;
         lock_ff        <= '0;
         pending_ff     <= 1'b0;
      end else if (work_go) begin
         ready_mask_ff  <= ready_mask_in;
         task_queued_ff <= task_queued_in;
         cur_ff         <= cur_in;
         cur_valid_ff   <= cur_valid_in;
         lock_ff        <= lock_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_go) begin
         if (hd_we)  level_head_ff[hd_a]  <= hd_d;
         if (hd2_we) level_head_ff[hd2_a] <= hd2_d;
         if (tl_we)  level_tail_ff[tl_a]  <= tl_d;
         if (nx_we)  link_next_ff[nx_a]   <= nx_d;
         if (nx2_we) link_next_ff[nx2_a]  <= nx2_d;
         if (pv_we)  link_prev_ff[pv_a]   <= pv_d;
         if (pv2_we) link_prev_ff[pv2_a]  <= pv2_d;
         if (lv_we)  task_level_ff[lv_a]  <= lv_d;
         if (pre_we) task_pre_ff[pre_a]   <= pre_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (work_go) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (work_go) begin
         st_ff     <= st_in;
         rtask_ff  <= ID_W'(cur_in);
         rvalid_ff <= cur_valid_in;
         // level of the running task as it stands after this operation
         rprio_ff  <= cur_valid_in ?
                      PRIO_W'((lv_we && lv_a == cur_in) ? lv_d
                                                        : task_level_ff[cur_in]) : '0;
         hprio_ff  <= PRIO_W'(ffs(ready_mask_in));
         rempty_ff <= (ready_mask_in == '0);
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = st_ff;
   assign rsp_running_task       = rtask_ff;
   assign rsp_running_prio       = rprio_ff;
   assign rsp_running_valid      = rvalid_ff;
   assign rsp_highest_ready_prio = hprio_ff;
   assign rsp_ready_empty        = rempty_ff;
endmodule

@@ sv/prqs_checker.sv @@
// port-level checks for the scheduler, bound to the top level
module prqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_running_task,
   input logic [4:0] rsp_running_prio,
   input logic       rsp_running_valid,
   input logic [4:0] rsp_highest_ready_prio,
   input logic       rsp_ready_empty
);
   import prqs_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   a_empty_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_empty |-> rsp_highest_ready_prio == 5'd0)
      else $error("empty queue reports a level");

   a_idle_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> rsp_running_prio == 5'd0
                                         && rsp_running_task == 5'd0)
      else $error("no running task but fields set");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd5)
      else $error("bad status code");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without back pressure");
endmodule

bind priority_ready_queue_scheduler_core prqs_checker u_prqs_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for the priority ready queue scheduler core
`timescale 1ns / 1ps

module tb_top;
   import prqs_pkg::*;

   localparam int NTASK     = 32;
   localparam int NLEVEL    = 32;
   localparam int N_RANDOM  = 1308;
   localparam int IDLE_MAX  = 2000;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] id;
      logic [4:0] prio;
      logic       pre;
      logic       still;
   } sched_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] run_task;
      logic [4:0] run_prio;
      logic       run_valid;
      logic [4:0] top_prio;
      logic       empty;
   } sched_rsp_type;

   typedef struct packed {
      sched_req_type rq;
      logic          fixed;
      sched_rsp_type rs;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [4:0] req_task_id = '0;
   logic [4:0] req_task_priority = '0;
   logic req_task_preemptible = 1'b0;
   logic req_running_still_ready = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [2:0] rsp_status;
   logic [4:0] rsp_running_task, rsp_running_prio, rsp_highest_ready_prio;
   logic rsp_running_valid, rsp_ready_empty;

   priority_ready_queue_scheduler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_task_id(req_task_id), .req_task_priority(req_task_priority),
      .req_task_preemptible(req_task_preemptible),
      .req_running_still_ready(req_running_still_ready),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_running_task(rsp_running_task), .rsp_running_prio(rsp_running_prio),
      .rsp_running_valid(rsp_running_valid),
      .rsp_highest_ready_prio(rsp_highest_ready_prio),
      .rsp_ready_empty(rsp_ready_empty)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // scheduler shadow state
   logic [31:0] rdy_mask;
   logic [4:0]  lvl_head [NLEVEL];
   logic [4:0]  lvl_tail [NLEVEL];
   logic [4:0]  nxt [NTASK];
   logic [4:0]  prv [NTASK];
   logic        queued [NTASK];
   logic [4:0]  tlevel [NTASK];
   logic        tpre [NTASK];
   logic [4:0]  cur_task;
   logic        cur_valid;
   logic [7:0]  lock_cnt;
   logic        pending;

   sched_rsp_type expected_rsp_q[$];
   sched_rsp_type fixed_rsp_q[$];
   logic       fixed_flag_q[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  stim_done = 0;
   bit  hold_long = 0;

   function automatic logic [4:0] first_set(logic [31:0] m);
      for (int i = 0; i < 32; i++)
         if (m[i]) return 5'(i);
      return 5'd0;
   endfunction

   task automatic shadow_enqueue(logic [4:0] id, logic [4:0] lvl, bit at_head);
      if (rdy_mask[lvl]) begin
         if (at_head) begin
            prv[lvl_head[lvl]] = id;
            nxt[id] = lvl_head[lvl];
            lvl_head[lvl] = id;
         end else begin
            nxt[lvl_tail[lvl]] = id;
            prv[id] = lvl_tail[lvl];
            lvl_tail[lvl] = id;
         end
      end else begin
         lvl_head[lvl] = id;
         lvl_tail[lvl] = id;
         rdy_mask[lvl] = 1'b1;
      end
      tlevel[id] = lvl;
      queued[id] = 1'b1;
   endtask

   task automatic shadow_unlink(logic [4:0] id);
      logic [4:0] lvl;
      lvl = tlevel[id];
      if (lvl_head[lvl] == id && lvl_tail[lvl] == id) rdy_mask[lvl] = 1'b0;
      else if (lvl_head[lvl] == id) lvl_head[lvl] = nxt[id];
      else if (lvl_tail[lvl] == id) lvl_tail[lvl] = prv[id];
      else begin
         nxt[prv[id]] = nxt[id];
         prv[nxt[id]] = prv[id];
      end
      queued[id] = 1'b0;
   endtask

   function automatic void scheduler_reset();
      rdy_mask = '0;
      for (int i = 0; i < NTASK; i++) begin
         queued[i] = 0; tlevel[i] = 0; tpre[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
      for (int i = 0; i < NLEVEL; i++) begin
         lvl_head[i] = 0; lvl_tail[i] = 0;
      end
      cur_task = 0; cur_valid = 0; lock_cnt = 0; pending = 0;
   endfunction

   task automatic predict_schedule(sched_req_type rq, output sched_rsp_type rs);
      logic [2:0] st;
      st = ST_OK;
      case (rq.op)
         OP_READY_TAIL, OP_READY_HEAD: begin
            if (!queued[rq.id]) begin
               tpre[rq.id] = rq.pre;
               shadow_enqueue(rq.id, rq.prio, rq.op == OP_READY_HEAD);
               if (cur_valid && tlevel[cur_task] > rq.prio && tpre[cur_task]) begin
                  if (lock_cnt == 0) st = ST_SWITCH_REQ;
                  else begin
                     pending = 1'b1;
                     st = ST_PENDING;
                  end
               end else st = ST_NOT_NEEDED;
            end
         end
         OP_SWITCH: begin
            if (rq.still && cur_valid && !queued[cur_task])
               shadow_enqueue(cur_task, tlevel[cur_task], 1'b1);
            if (rdy_mask == 0) st = ST_EMPTY;
            else begin
               cur_task = lvl_head[first_set(rdy_mask)];
               shadow_unlink(cur_task);
               cur_valid = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (queued[rq.id]) shadow_unlink(rq.id);
            else st = ST_NOT_QUEUED;
         end
         OP_LOCK: begin
            if (cur_valid && tpre[cur_task] && lock_cnt < LOCK_MAX) lock_cnt++;
         end
         OP_UNLOCK: begin
            if (lock_cnt != 0) begin
               lock_cnt--;
               if (lock_cnt == 0 && pending) begin
                  pending = 1'b0;
                  st = ST_SWITCH_REQ;
               end
            end
         end
         default: ;
      endcase
      rs.status = st;
      rs.run_task = cur_task;
      rs.run_prio = cur_valid ? tlevel[cur_task] : 5'd0;
      rs.run_valid = cur_valid;
      rs.top_prio = first_set(rdy_mask);
      rs.empty = (rdy_mask == 0);
   endtask

   task automatic send_item(sched_req_type rq, bit fixed, sched_rsp_type fx, bit no_gap);
      sched_rsp_type pr;
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      predict_schedule(rq, pr);
      expected_rsp_q.push_back(pr);
      fixed_rsp_q.push_back(fx);
      fixed_flag_q.push_back(fixed);
      @(posedge clock);
      req_valid <= 1'b1;
      req_opcode <= rq.op;
      req_task_id <= rq.id;
      req_task_priority <= rq.prio;
      req_task_preemptible <= rq.pre;
      req_running_still_ready <= rq.still;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge; the next driver step updates or drops valid
      req_valid <= 1'b0;
   endtask

   function automatic sched_req_type mk(int op, int id, int prio, int pre, int still);
      sched_req_type r;
      r.op = 3'(op); r.id = 5'(id); r.prio = 5'(prio); r.pre = 1'(pre);
      r.still = 1'(still);
      return r;
   endfunction

   function automatic sched_rsp_type rsp_of(int st, int t, int p, int v, int hp, int e);
      sched_rsp_type r;
      r.status = 3'(st); r.run_task = 5'(t); r.run_prio = 5'(p); r.run_valid = 1'(v);
      r.top_prio = 5'(hp); r.empty = 1'(e);
      return r;
   endfunction

   function automatic sched_req_type random_req(bit well_formed);
      sched_req_type r;
      int pick;
      r = mk(int'($urandom_range(0, 7)), int'($urandom_range(0, 31)),
             int'($urandom_range(0, 31)), int'($urandom_range(0, 1)),
             int'($urandom_range(0, 1)));
      if (well_formed) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) r.op = ($urandom_range(0, 1) == 0) ? OP_READY_TAIL : OP_READY_HEAD;
         else if (pick < 62) r.op = OP_SWITCH;
         else if (pick < 78) r.op = OP_REMOVE;
         else if (pick < 89) r.op = OP_LOCK;
         else r.op = OP_UNLOCK;
         // keep levels clustered so queues get several entries
         if ($urandom_range(0, 2) != 0) r.prio = 5'($urandom_range(0, 5));
         if (r.op == OP_REMOVE && $urandom_range(0, 3) != 0) r.id = 5'($urandom_range(0, 15));
         if (r.op != OP_REMOVE && $urandom_range(0, 1) == 0) r.id = 5'($urandom_range(0, 15));
      end
      return r;
   endfunction

   stim_row_type dir_table[] = '{
      '{mk(OP_SWITCH, 0, 0, 0, 1), 1'b1, rsp_of(ST_EMPTY, 0, 0, 0, 0, 1)},
      '{mk(OP_LOCK, 0, 0, 0, 0), 1'b1, rsp_of(ST_OK, 0, 0, 0, 0, 1)},
      '{mk(OP_UNLOCK, 0, 0, 0, 0), 1'b1, rsp_of(ST_OK, 0, 0, 0, 0, 1)},
      '{mk(OP_REMOVE, 31, 0, 0, 0), 1'b1, rsp_of(ST_NOT_QUEUED, 0, 0, 0, 0, 1)},
      '{mk(6, 0, 0, 0, 0), 1'b1, rsp_of(ST_OK, 0, 0, 0, 0, 1)},
      '{mk(7, 31, 31, 1, 1), 1'b1, rsp_of(ST_OK, 0, 0, 0, 0, 1)},
      '{mk(OP_READY_TAIL, 31, 31, 1, 0), 1'b1, rsp_of(ST_NOT_NEEDED, 0, 0, 0, 31, 0)},
      '{mk(OP_READY_TAIL, 31, 0, 1, 0), 1'b1, rsp_of(ST_OK, 0, 0, 0, 31, 0)},
      '{mk(OP_SWITCH, 0, 0, 0, 0), 1'b1, rsp_of(ST_OK, 31, 31, 1, 0, 1)},
      '{mk(OP_READY_TAIL, 1, 3, 0, 0), 1'b0, '0},
      '{mk(OP_LOCK, 0, 0, 0, 0), 1'b0, '0},
      '{mk(OP_READY_HEAD, 2, 0, 1, 0), 1'b0, '0},
      '{mk(OP_READY_TAIL, 3, 3, 1, 0), 1'b0, '0},
      '{mk(OP_READY_HEAD, 4, 3, 0, 0), 1'b0, '0},
      '{mk(OP_UNLOCK, 0, 0, 0, 0), 1'b0, '0},
      '{mk(OP_REMOVE, 1, 0, 0, 0), 1'b0, '0},
      '{mk(OP_SWITCH, 0, 0, 0, 1), 1'b0, '0},
      '{mk(OP_SWITCH, 0, 0, 0, 1), 1'b0, '0},
      '{mk(OP_REMOVE, 3, 0, 0, 0), 1'b0, '0},
      '{mk(OP_SWITCH, 0, 0, 0, 0), 1'b0, '0},
      '{mk(OP_SWITCH, 0, 0, 0, 0), 1'b0, '0},
      '{mk(OP_SWITCH, 0, 0, 0, 1), 1'b0, '0}
   };

   // sender
   initial begin
      scheduler_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[i])
         send_item(dir_table[i].rq, dir_table[i].fixed, dir_table[i].rs, 1'b0);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 300) begin
            // pause until the block has drained
            while (expected_rsp_q.size() != 0) @(posedge clock);
         end
         if (n == 600) hold_long = 1;
         if (n == 900) begin
            // lock count saturation run
            for (int k = 0; k < 260; k++)
               send_item(mk(OP_LOCK, 0, 0, 0, 0), 1'b0, '0, 1'b1);
            for (int k = 0; k < 260; k++)
               send_item(mk(OP_UNLOCK, 0, 0, 0, 0), 1'b0, '0, 1'b1);
         end
         send_item(random_req($urandom_range(0, 9) != 0), 1'b0, '0,
                   (n >= 600 && n < 640));
      end
      stim_done = 1;
   end

   // receiver stall
   initial begin
      int wait_cyc;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            hold_long = 0;
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
         end
         wait_cyc = $urandom_range(0, 15);
         if ($urandom_range(0, 3) == 0) wait_cyc = 0;
         if (wait_cyc != 0) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (wait_cyc - 1) @(posedge clock);
         end
         @(posedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         rsp_stall <= 1'b1;
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      sched_rsp_type got, exp_rs, fx;
      logic fixed;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            got = rsp_of(rsp_status, rsp_running_task, rsp_running_prio,
                         rsp_running_valid, rsp_highest_ready_prio, rsp_ready_empty);
            if (expected_rsp_q.size() == 0) begin
               $display("%0t unexpected result expected none actual %h", $time, got);
               errors++;
            end else begin
               exp_rs = expected_rsp_q.pop_front();
               fx = fixed_rsp_q.pop_front();
               fixed = fixed_flag_q.pop_front();
               if (fixed) exp_rs = fx;
               if (got.status !== exp_rs.status)
                  $display("%0t status expected %0d actual %0d", $time, exp_rs.status, got.status);
               if (got.run_task !== exp_rs.run_task)
                  $display("%0t running_task expected %0d actual %0d", $time,
                           exp_rs.run_task, got.run_task);
               if (got.run_prio !== exp_rs.run_prio)
                  $display("%0t running_prio expected %0d actual %0d", $time,
                           exp_rs.run_prio, got.run_prio);
               if (got.run_valid !== exp_rs.run_valid)
                  $display("%0t running_valid expected %0d actual %0d", $time,
                           exp_rs.run_valid, got.run_valid);
               if (got.top_prio !== exp_rs.top_prio)
                  $display("%0t highest_ready_prio expected %0d actual %0d", $time,
                           exp_rs.top_prio, got.top_prio);
               if (got.empty !== exp_rs.empty)
                  $display("%0t ready_empty expected %0d actual %0d", $time,
                           exp_rs.empty, got.empty);
               if (got !== exp_rs) errors++;
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      while (!(stim_done && expected_rsp_q.size() == 0) && idle_cycles < IDLE_MAX)
         @(posedge clock);
      if (idle_cycles >= IDLE_MAX) begin
         $display("priority_ready_queue_scheduler_core regression: fail");
      end else begin
         repeat (10) @(posedge clock);
         if (errors == 0) begin
            $display("priority_ready_queue_scheduler_core regression: pass");
         end else begin
            $display("priority_ready_queue_scheduler_core regression: fail");
         end
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/prqs_pkg.sv
sv/priority_ready_queue_scheduler_core.sv
sv/prqs_checker.sv
tb/tb_top.sv
